// File: hdl/igta_pkg.sv
// ----------------------------------------------------------------------------
// igta_pkg
// Types, field widths and codes shared by the track association block.
// ----------------------------------------------------------------------------
package igta_pkg;

    // field widths
    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 13;
    localparam int CONF_W     = 16;
    localparam int AGE_W      = 8;
    localparam int FRAME_W    = 31;
    localparam int ID_W       = 32;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // shared multiplier and IoU operand widths
    localparam int MUL_W  = 27;
    localparam int PROD_W = 2 * MUL_W;
    localparam int AREA_W = 2 * SIZE_W;
    localparam int UNI_W  = AREA_W + 1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_FRESH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COAST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IOU_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE  = 2'd2;

    // one track record as held in the table
    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
        logic [CONF_W-1:0]         conf;
        logic [AGE_W-1:0]          age;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic [FRAME_W-1:0]        frame;
    } t_rec;

    // saturate a 17 bit signed sum to 16 bits
    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [COORD_W:0] v);
        logic signed [COORD_W-1:0] r;
        if (v[COORD_W] != v[COORD_W-1]) begin
            r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/igta_if.sv
// ----------------------------------------------------------------------------
// igta_if
// Valid/ready channels for detection words in and track words out.
// ----------------------------------------------------------------------------
interface igta_det_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   action;
    logic signed [igta_pkg::COORD_W-1:0]    box_x;
    logic signed [igta_pkg::COORD_W-1:0]    box_y;
    logic [igta_pkg::SIZE_W-1:0]            box_w;
    logic [igta_pkg::SIZE_W-1:0]            box_h;
    logic [igta_pkg::CONF_W-1:0]            confidence;
    logic [igta_pkg::FRAME_W-1:0]           frame_number;

    modport source(output valid, action, box_x, box_y, box_w, box_h, confidence,
                   frame_number, input ready);
    modport sink(input valid, action, box_x, box_y, box_w, box_h, confidence,
                 frame_number, output ready);
endinterface

interface igta_trk_if;
    logic                                   valid;
    logic                                   ready;
    logic [igta_pkg::KIND_W-1:0]            kind;
    logic [igta_pkg::ID_W-1:0]              track_id;
    logic signed [igta_pkg::COORD_W-1:0]    out_x;
    logic signed [igta_pkg::COORD_W-1:0]    out_y;
    logic [igta_pkg::SIZE_W-1:0]            out_w;
    logic [igta_pkg::SIZE_W-1:0]            out_h;
    logic [igta_pkg::CONF_W-1:0]            out_confidence;
    logic [igta_pkg::AGE_W-1:0]             age;
    logic [igta_pkg::FRAME_W-1:0]           last_update;
    logic signed [igta_pkg::COORD_W-1:0]    vel_x;
    logic signed [igta_pkg::COORD_W-1:0]    vel_y;
    logic                                   last;

    modport source(output valid, kind, track_id, out_x, out_y, out_w, out_h,
                   out_confidence, age, last_update, vel_x, vel_y, last, input ready);
    modport sink(input valid, kind, track_id, out_x, out_y, out_w, out_h,
                 out_confidence, age, last_update, vel_x, vel_y, last, output ready);
endinterface

// File: hdl/iou_greedy_track_association.sv
// ----------------------------------------------------------------------------
// iou_greedy_track_association
// Greedy IoU association of detections to the previous frame's tracks,
// with coasting of unmatched tracks at end of frame and two table banks.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_det     in   valid/ready        action, box, confidence, frame_number
//  o_trk     out  valid/ready        kind, track record, last
//  i_cfg_*   in   write enable only  register index, 16 bit data
//
//  One word at a time. A detection is scanned against every valid
//  previous-frame slot through one shared multiplier, then the new bank is
//  searched for its id or a free slot; a dropped one goes straight back to idle.
//  End of frame walks the slots, skips matched ones, does a lookup and a put
//  for each unmatched track that coasts, then emits the done word.
//  Synchronous reset clears the valid flops; a stalled output holds the put step.
// ----------------------------------------------------------------------------
module iou_greedy_track_association #(
    parameter int TRACK_SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [igta_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [igta_pkg::CFG_DATA_W-1:0] i_cfg_data,
    igta_det_if.sink                      i_det,
    igta_trk_if.source                    o_trk
);
    import igta_pkg::*;

    localparam int SW    = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int CW    = $clog2(TRACK_SLOTS + 1);
    localparam int DEPTH = 2 * TRACK_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CW-1:0] LAST_I = CW'(TRACK_SLOTS);

    // sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_DAREA = 5'd1;
    localparam logic [4:0] ST_DAR2  = 5'd2;
    localparam logic [4:0] ST_S_RD  = 5'd3;
    localparam logic [4:0] ST_S_IX  = 5'd4;
    localparam logic [4:0] ST_S_INT = 5'd5;
    localparam logic [4:0] ST_S_UNI = 5'd6;
    localparam logic [4:0] ST_S_M1  = 5'd7;
    localparam logic [4:0] ST_S_M2  = 5'd8;
    localparam logic [4:0] ST_S_M3  = 5'd9;
    localparam logic [4:0] ST_S_CMP = 5'd10;
    localparam logic [4:0] ST_D_RES = 5'd11;
    localparam logic [4:0] ST_F_RD  = 5'd12;
    localparam logic [4:0] ST_F_CHK = 5'd13;
    localparam logic [4:0] ST_W_PUT = 5'd14;
    localparam logic [4:0] ST_E_RD  = 5'd15;
    localparam logic [4:0] ST_E_DAT = 5'd16;
    localparam logic [4:0] ST_E_FIN = 5'd17;

    // control
    logic [4:0]        r_state;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_j;
    logic              r_bank;
    logic [ID_W-1:0]   r_next_id;
    logic              r_eof;
    logic              r_found;
    logic              r_hit;
    logic              r_free_ok;
    logic              r_out_valid;
    logic [CONF_W-1:0] r_conf_thr;
    logic [CONF_W-1:0] r_iou_thr;
    logic [AGE_W-1:0]  r_max_age;
    logic              r_valid   [DEPTH];
    logic              r_matched [TRACK_SLOTS];

    // payload
    t_rec              r_det;
    logic [AREA_W-1:0] r_darea;
    logic [AREA_W-1:0] r_sarea;
    logic [SIZE_W-1:0] r_ix;
    logic [SIZE_W-1:0] r_iy;
    logic [AREA_W-1:0] r_inter;
    logic [UNI_W-1:0]  r_uni;
    logic              r_c1;
    logic [PROD_W-1:0] r_p2;
    logic [SW-1:0]     r_bslot;
    logic [AREA_W-1:0] r_bi;
    logic [UNI_W-1:0]  r_bu;
    logic [ID_W-1:0]   r_bid;
    logic signed [COORD_W-1:0] r_bx;
    logic signed [COORD_W-1:0] r_by;
    logic [SW-1:0]     r_hit_idx;
    logic [SW-1:0]     r_free_idx;
    t_rec              r_wrec;
    t_rec              r_out;
    logic [KIND_W-1:0] r_out_kind;
    logic              r_out_last;

    // datapath wires
    logic [MUL_W-1:0]  w_ma;
    logic [MUL_W-1:0]  w_mb;
    logic [PROD_W-1:0] w_p;
    t_rec              w_rd;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic              w_out_free;
    logic              w_out_load;
    logic              w_store_ok;
    logic [SW-1:0]     w_store_idx;
    logic [AW-1:0]     w_old_addr;
    logic [AW-1:0]     w_new_addr_j;
    logic [SW-1:0]     w_i_idx;
    logic [SW-1:0]     w_j_idx;
    logic [SIZE_W-1:0] w_ix;
    logic [SIZE_W-1:0] w_iy;
    logic [AGE_W-1:0]  w_age;

    function automatic logic [AW-1:0] slot_addr(input logic bank, input logic [SW-1:0] idx);
        return bank ? AW'(TRACK_SLOTS) + AW'(idx) : AW'(idx);
    endfunction

    assign w_i_idx      = r_i[SW-1:0];
    assign w_j_idx      = r_j[SW-1:0];
    assign w_old_addr   = slot_addr(r_bank, w_i_idx);
    assign w_new_addr_j = slot_addr(!r_bank, w_j_idx);
    assign w_out_free   = !r_out_valid || o_trk.ready;
    assign w_out_load   = (r_state == ST_W_PUT || r_state == ST_E_FIN) && w_out_free;
    assign w_store_ok   = r_hit || r_free_ok;
    assign w_store_idx  = r_hit ? r_hit_idx : r_free_idx;

    igta_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    igta_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_wrec),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_DAREA: begin
                w_ma = MUL_W'(r_det.w);
                w_mb = MUL_W'(r_det.h);
            end
            ST_S_IX: begin
                w_ma = MUL_W'(w_rd.w);
                w_mb = MUL_W'(w_rd.h);
            end
            ST_S_INT: begin
                w_ma = MUL_W'(r_ix);
                w_mb = MUL_W'(r_iy);
            end
            ST_S_M1: begin
                w_ma = MUL_W'(r_iou_thr);
                w_mb = MUL_W'(r_uni);
            end
            ST_S_M2: begin
                w_ma = MUL_W'(r_inter);
                w_mb = MUL_W'(r_bu);
            end
            ST_S_M3: begin
                w_ma = MUL_W'(r_bi);
                w_mb = MUL_W'(r_uni);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // overlap extents of the detection and the slot just read
    always_comb begin
        logic signed [COORD_W+1:0] rs, rdet, ls, ld, mr, ml, d;
        rs   = (COORD_W+2)'(w_rd.x) + $signed({3'b000, w_rd.w});
        rdet = (COORD_W+2)'(r_det.x) + $signed({3'b000, r_det.w});
        ls   = (COORD_W+2)'(w_rd.x);
        ld   = (COORD_W+2)'(r_det.x);
        mr   = (rs < rdet) ? rs : rdet;
        ml   = (ls > ld) ? ls : ld;
        d    = mr - ml;
        w_ix = (d > 0) ? d[SIZE_W-1:0] : '0;
        rs   = (COORD_W+2)'(w_rd.y) + $signed({3'b000, w_rd.h});
        rdet = (COORD_W+2)'(r_det.y) + $signed({3'b000, r_det.h});
        ls   = (COORD_W+2)'(w_rd.y);
        ld   = (COORD_W+2)'(r_det.y);
        mr   = (rs < rdet) ? rs : rdet;
        ml   = (ls > ld) ? ls : ld;
        d    = mr - ml;
        w_iy = (d > 0) ? d[SIZE_W-1:0] : '0;
    end

    // coasting age, saturating
    assign w_age = (w_rd.age == {AGE_W{1'b1}}) ? w_rd.age : w_rd.age + AGE_W'(1);

    // table read and write ports
    always_comb begin
        w_re    = 1'b0;
        w_raddr = w_old_addr;
        if ((r_state == ST_S_RD || r_state == ST_E_RD) && r_i != LAST_I) begin
            w_re = r_valid[w_old_addr] && !(r_state == ST_E_RD && r_matched[w_i_idx]);
        end else if (r_state == ST_F_RD && r_j != LAST_I) begin
            w_re    = r_valid[w_new_addr_j];
            w_raddr = w_new_addr_j;
        end
    end

    assign w_we    = (r_state == ST_W_PUT) && w_out_free && w_store_ok;
    assign w_waddr = slot_addr(!r_bank, w_store_idx);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_bank      <= 1'b0;
            r_next_id   <= '0;
            r_eof       <= 1'b0;
            r_found     <= 1'b0;
            r_hit       <= 1'b0;
            r_free_ok   <= 1'b0;
            r_out_valid <= 1'b0;
            r_conf_thr  <= CONF_W'(32768);
            r_iou_thr   <= CONF_W'(19661);
            r_max_age   <= AGE_W'(30);
            for (int k = 0; k < DEPTH; k++) begin
                r_valid[k] <= 1'b0;
            end
            for (int k = 0; k < TRACK_SLOTS; k++) begin
                r_matched[k] <= 1'b0;
            end
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CONF_THR: r_conf_thr <= i_cfg_data[CONF_W-1:0];
                    CFG_IOU_THR:  r_iou_thr  <= i_cfg_data[CONF_W-1:0];
                    CFG_MAX_AGE:  r_max_age  <= i_cfg_data[AGE_W-1:0];
                    default: ;
                endcase
            end

            // output register
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_trk.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_det.valid) begin
                        r_det.x     <= i_det.box_x;
                        r_det.y     <= i_det.box_y;
                        r_det.w     <= i_det.box_w;
                        r_det.h     <= i_det.box_h;
                        r_det.conf  <= i_det.confidence;
                        r_det.frame <= i_det.frame_number;
                        r_eof       <= i_det.action;
                        r_i         <= '0;
                        if (i_det.action) begin
                            r_state <= ST_E_RD;
                        end else if (i_det.confidence >= r_conf_thr) begin
                            r_state <= ST_DAREA;
                        end
                    end
                end
                ST_DAREA: begin
                    r_state <= ST_DAR2;
                end
                ST_DAR2: begin
                    r_darea <= w_p[AREA_W-1:0];
                    r_found <= 1'b0;
                    r_bi    <= '0;
                    r_bu    <= UNI_W'(1);
                    r_state <= ST_S_RD;
                end
                // scan previous-frame slots
                ST_S_RD: begin
                    if (r_i == LAST_I) begin
                        r_state <= ST_D_RES;
                    end else if (!r_valid[w_old_addr]) begin
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_state <= ST_S_IX;
                    end
                end
                ST_S_IX: begin
                    r_ix    <= w_ix;
                    r_iy    <= w_iy;
                    r_state <= ST_S_INT;
                end
                ST_S_INT: begin
                    r_sarea <= w_p[AREA_W-1:0];
                    r_state <= ST_S_UNI;
                end
                ST_S_UNI: begin
                    r_inter <= w_p[AREA_W-1:0];
                    r_uni   <= UNI_W'(r_sarea) + UNI_W'(r_darea) - UNI_W'(w_p[AREA_W-1:0]);
                    r_state <= ST_S_M1;
                end
                ST_S_M1: begin
                    r_state <= ST_S_M2;
                end
                ST_S_M2: begin
                    r_c1    <= PROD_W'({r_inter, 16'h0000}) > w_p;
                    r_state <= ST_S_M3;
                end
                ST_S_M3: begin
                    r_p2    <= w_p;
                    r_state <= ST_S_CMP;
                end
                ST_S_CMP: begin
                    if (r_uni != '0 && r_c1 && r_p2 > w_p) begin
                        r_found <= 1'b1;
                        r_bslot <= w_i_idx;
                        r_bi    <= r_inter;
                        r_bu    <= r_uni;
                        r_bid   <= w_rd.id;
                        r_bx    <= w_rd.x;
                        r_by    <= w_rd.y;
                    end
                    r_i     <= r_i + CW'(1);
                    r_state <= ST_S_RD;
                end
                // build the detection record
                ST_D_RES: begin
                    r_wrec.x     <= r_det.x;
                    r_wrec.y     <= r_det.y;
                    r_wrec.w     <= r_det.w;
                    r_wrec.h     <= r_det.h;
                    r_wrec.conf  <= r_det.conf;
                    r_wrec.frame <= r_det.frame;
                    r_wrec.age   <= '0;
                    if (r_found) begin
                        r_matched[r_bslot] <= 1'b1;
                        r_wrec.id <= r_bid;
                        r_wrec.vx <= sat16((COORD_W+1)'(r_det.x) - (COORD_W+1)'(r_bx));
                        r_wrec.vy <= sat16((COORD_W+1)'(r_det.y) - (COORD_W+1)'(r_by));
                    end else begin
                        r_wrec.id <= r_next_id;
                        r_wrec.vx <= '0;
                        r_wrec.vy <= '0;
                        r_next_id <= r_next_id + ID_W'(1);
                    end
                    r_j       <= '0;
                    r_hit     <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_state   <= ST_F_RD;
                end
                // find the store slot in the new bank
                ST_F_RD: begin
                    if (r_j == LAST_I) begin
                        r_state <= ST_W_PUT;
                    end else if (!r_valid[w_new_addr_j]) begin
                        if (!r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= w_j_idx;
                        end
                        r_j <= r_j + CW'(1);
                    end else begin
                        r_state <= ST_F_CHK;
                    end
                end
                ST_F_CHK: begin
                    if (w_rd.id == r_wrec.id) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= w_j_idx;
                        r_state   <= ST_W_PUT;
                    end else begin
                        r_j     <= r_j + CW'(1);
                        r_state <= ST_F_RD;
                    end
                end
                // store and emit
                ST_W_PUT: begin
                    if (w_out_free) begin
                        if (w_store_ok) begin
                            r_valid[w_waddr] <= 1'b1;
                        end
                        r_out       <= r_wrec;
                        r_out_last  <= !r_eof;
                        if (r_eof) begin
                            r_out_kind <= KIND_COAST;
                            r_i        <= r_i + CW'(1);
                            r_state    <= ST_E_RD;
                        end else begin
                            r_out_kind <= w_store_ok ? KIND_FRESH : KIND_FULL;
                            r_state    <= ST_IDLE;
                        end
                    end
                end
                // end of frame: walk unmatched previous tracks
                ST_E_RD: begin
                    if (r_i == LAST_I) begin
                        r_state <= ST_E_FIN;
                    end else if (!r_valid[w_old_addr] || r_matched[w_i_idx]) begin
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_state <= ST_E_DAT;
                    end
                end
                ST_E_DAT: begin
                    if (w_age >= r_max_age) begin
                        r_i     <= r_i + CW'(1);
                        r_state <= ST_E_RD;
                    end else begin
                        r_wrec     <= '{id: w_rd.id,
                                        x: sat16((COORD_W+1)'(w_rd.x) + (COORD_W+1)'(w_rd.vx)),
                                        y: sat16((COORD_W+1)'(w_rd.y) + (COORD_W+1)'(w_rd.vy)),
                                        w: w_rd.w, h: w_rd.h, conf: w_rd.conf, age: w_age,
                                        vx: w_rd.vx, vy: w_rd.vy, frame: w_rd.frame};
                        r_j        <= '0;
                        r_hit      <= 1'b0;
                        r_free_ok  <= 1'b0;
                        r_state    <= ST_F_RD;
                    end
                end
                ST_E_FIN: begin
                    if (w_out_free) begin
                        r_out       <= '0;
                        r_out_kind  <= KIND_DONE;
                        r_out_last  <= 1'b1;
                        for (int k = 0; k < TRACK_SLOTS; k++) begin
                            r_valid[slot_addr(r_bank, SW'(k))] <= 1'b0;
                            r_matched[k] <= 1'b0;
                        end
                        r_bank  <= !r_bank;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // ports
    assign i_det.ready          = (r_state == ST_IDLE);
    assign o_trk.valid          = r_out_valid;
    assign o_trk.kind           = r_out_kind;
    assign o_trk.track_id       = r_out.id;
    assign o_trk.out_x          = r_out.x;
    assign o_trk.out_y          = r_out.y;
    assign o_trk.out_w          = r_out.w;
    assign o_trk.out_h          = r_out.h;
    assign o_trk.out_confidence = r_out.conf;
    assign o_trk.age            = r_out.age;
    assign o_trk.last_update    = r_out.frame;
    assign o_trk.vel_x          = r_out.vx;
    assign o_trk.vel_y          = r_out.vy;
    assign o_trk.last           = r_out_last;

    // frame close clears match marks and swaps the banks
    a_frame_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_E_FIN && w_out_free) |=> (r_bank != $past(r_bank) && !r_matched[0]))
        else $error("frame close did not swap banks or clear match marks");

    // tracks are only ever written into the new bank
    a_new_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_bank ? (w_waddr < AW'(TRACK_SLOTS)) : (w_waddr >= AW'(TRACK_SLOTS))))
        else $error("table write into the previous-frame bank");

    // the frame done word always closes the item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_trk.valid && o_trk.kind == KIND_DONE) |-> (o_trk.last && o_trk.track_id == '0))
        else $error("frame done word without last");

endmodule

// File: hdl/igta_mul.sv
// ----------------------------------------------------------------------------
// igta_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module igta_mul (
    input  logic                        i_clk,
    input  logic [igta_pkg::MUL_W-1:0]  i_a,
    input  logic [igta_pkg::MUL_W-1:0]  i_b,
    output logic [igta_pkg::PROD_W-1:0] o_p
);
    import igta_pkg::*;

    logic [PROD_W-1:0] r_p;

    // product is registered and lands in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: hdl/igta_table.sv
// ----------------------------------------------------------------------------
// igta_table
// Two-bank track record memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module igta_table #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  igta_pkg::t_rec   i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output igta_pkg::t_rec   o_rdata
);
    import igta_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: dv/tb_iou_greedy_track_association.sv
// ----------------------------------------------------------------------------
// tb_iou_greedy_track_association
// Self-checking bench for the IoU track association block: frames of moving
// boxes and random noise words are driven with bursty valid and a stalling
// ready, a scoreboard predicts every track word and compares field by field.
// ----------------------------------------------------------------------------
module tb_iou_greedy_track_association;
    import igta_pkg::*;

    localparam int  SLOTS      = 16;
    localparam int  DRAIN_WAIT = 700;
    localparam longint CYCLE_LIMIT = 1000000;

    // one detection word as driven
    typedef struct packed {
        logic                      action;
        logic signed [COORD_W-1:0] box_x;
        logic signed [COORD_W-1:0] box_y;
        logic [SIZE_W-1:0]         box_w;
        logic [SIZE_W-1:0]         box_h;
        logic [CONF_W-1:0]         confidence;
        logic [FRAME_W-1:0]        frame_number;
    } det_word_t;

    // one track word as seen on the output
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [ID_W-1:0]           track_id;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic [SIZE_W-1:0]         out_w;
        logic [SIZE_W-1:0]         out_h;
        logic [CONF_W-1:0]         out_confidence;
        logic [AGE_W-1:0]          age;
        logic [FRAME_W-1:0]        last_update;
        logic signed [COORD_W-1:0] vel_x;
        logic signed [COORD_W-1:0] vel_y;
        logic                      last;
    } trk_word_t;

    // track table model and queue of expected track words
    class track_scoreboard;
        int unsigned conf_thr;
        int unsigned iou_thr;
        int unsigned age_limit;
        bit          occupied[2*SLOTS];
        bit          claimed[SLOTS];
        t_rec        tracks[2*SLOTS];
        bit          bank;
        logic [ID_W-1:0] fresh_id;
        trk_word_t   expected_words[$];
        int          errors;

        function new();
            conf_thr  = 32768;
            iou_thr   = 19661;
            age_limit = 30;
            bank      = 0;
            fresh_id  = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CONF_THR: conf_thr  = val;
                CFG_IOU_THR:  iou_thr   = val;
                CFG_MAX_AGE:  age_limit = val[AGE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [COORD_W-1:0] clip16(longint v);
            if (v > 32767) return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return v[COORD_W-1:0];
        endfunction

        // same id first, else lowest free slot, else -1
        function int store_slot(int base, logic [ID_W-1:0] id);
            for (int i = 0; i < SLOTS; i++)
                if (occupied[base+i] && tracks[base+i].id == id) return base + i;
            for (int i = 0; i < SLOTS; i++)
                if (!occupied[base+i]) return base + i;
            return -1;
        endfunction

        // append one expected word at the tail of the queue
        function void expect_word(trk_word_t o);
            expected_words.insert(expected_words.size(), o);
        endfunction

        function void note_word(det_word_t d);
            int oldb, newb, best, k, s;
            longint x, y, w, h, ix, iy, inter, uni, bi, bu, lo, hi;
            longint tx, ty, tw, th;
            logic [ID_W-1:0] id;
            logic signed [COORD_W-1:0] vx, vy;
            logic [AGE_W-1:0] nage;
            t_rec r;
            trk_word_t o;
            oldb = bank ? SLOTS : 0;
            newb = bank ? 0 : SLOTS;
            if (d.action == 1'b0) begin
                if (d.confidence < conf_thr) return;
                x = d.box_x; y = d.box_y; w = d.box_w; h = d.box_h;
                best = -1; bi = 0; bu = 1;
                for (int i = 0; i < SLOTS; i++) begin
                    k = oldb + i;
                    if (!occupied[k]) continue;
                    tx = tracks[k].x; ty = tracks[k].y;
                    tw = tracks[k].w; th = tracks[k].h;
                    hi = (tx + tw < x + w) ? tx + tw : x + w;
                    lo = (tx > x) ? tx : x;
                    ix = hi - lo;
                    hi = (ty + th < y + h) ? ty + th : y + h;
                    lo = (ty > y) ? ty : y;
                    iy = hi - lo;
                    inter = (ix > 0 ? ix : 0) * (iy > 0 ? iy : 0);
                    uni = tw * th + w * h - inter;
                    if (uni <= 0) continue;
                    if (inter * 65536 > longint'(iou_thr) * uni && inter * bu > bi * uni) begin
                        best = i; bi = inter; bu = uni;
                    end
                end
                vx = '0; vy = '0;
                if (best >= 0) begin
                    k = oldb + best;
                    claimed[best] = 1'b1;
                    id = tracks[k].id;
                    vx = clip16(x - tracks[k].x);
                    vy = clip16(y - tracks[k].y);
                end else begin
                    id = fresh_id;
                    fresh_id = fresh_id + 1;
                end
                s = store_slot(newb, id);
                r = '{id: id, x: d.box_x, y: d.box_y, w: d.box_w, h: d.box_h,
                      conf: d.confidence, age: '0, vx: vx, vy: vy, frame: d.frame_number};
                if (s >= 0) begin
                    occupied[s] = 1'b1;
                    tracks[s] = r;
                end
                o = '{kind: (s >= 0) ? KIND_FRESH : KIND_FULL, track_id: id,
                      out_x: r.x, out_y: r.y, out_w: r.w, out_h: r.h,
                      out_confidence: r.conf, age: '0, last_update: r.frame,
                      vel_x: vx, vel_y: vy, last: 1'b1};
                expect_word(o);
                return;
            end
            // end of frame: coast unmatched tracks in slot order
            for (int i = 0; i < SLOTS; i++) begin
                k = oldb + i;
                if (!occupied[k] || claimed[i]) continue;
                nage = (tracks[k].age < 8'd255) ? tracks[k].age + 8'd1 : 8'd255;
                if (nage >= age_limit) continue;
                r = tracks[k];
                r.age = nage;
                r.x = clip16(longint'(tracks[k].x) + tracks[k].vx);
                r.y = clip16(longint'(tracks[k].y) + tracks[k].vy);
                s = store_slot(newb, r.id);
                if (s >= 0) begin
                    occupied[s] = 1'b1;
                    tracks[s] = r;
                end
                o = '{kind: KIND_COAST, track_id: r.id, out_x: r.x, out_y: r.y,
                      out_w: r.w, out_h: r.h, out_confidence: r.conf, age: r.age,
                      last_update: r.frame, vel_x: r.vx, vel_y: r.vy, last: 1'b0};
                expect_word(o);
            end
            o = '0;
            o.kind = KIND_DONE;
            o.last = 1'b1;
            expect_word(o);
            for (int i = 0; i < SLOTS; i++) begin
                occupied[oldb+i] = 1'b0;
                claimed[i] = 1'b0;
            end
            bank = ~bank;
        endfunction

        function void check_word(trk_word_t got);
            trk_word_t want;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected track word kind=%0d id=%0d", got.kind, got.track_id);
                return;
            end
            want = expected_words.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp: kind=%0d id=%0d x=%0d y=%0d w=%0d h=%0d c=%0d a=%0d f=%0d v=%0d,%0d l=%0d",
                             want.kind, want.track_id, want.out_x, want.out_y, want.out_w,
                             want.out_h, want.out_confidence, want.age, want.last_update,
                             want.vel_x, want.vel_y, want.last);
                    $display("         got: kind=%0d id=%0d x=%0d y=%0d w=%0d h=%0d c=%0d a=%0d f=%0d v=%0d,%0d l=%0d",
                             got.kind, got.track_id, got.out_x, got.out_y, got.out_w,
                             got.out_h, got.out_confidence, got.age, got.last_update,
                             got.vel_x, got.vel_y, got.last);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    igta_det_if det_ch();
    igta_trk_if trk_ch();

    iou_greedy_track_association #(.TRACK_SLOTS(SLOTS)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_det      (det_ch),
        .o_trk      (trk_ch)
    );

    track_scoreboard sb = new();
    longint cycles;
    int     burst_left;
    int     words_sent;
    int     rx_mode;
    int     rx_hold;
    int     frame_no;

    // scene objects for well-formed frames
    int obj_x[5], obj_y[5], obj_w[5], obj_h[5], obj_vx[5], obj_vy[5];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // cycle count and run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_iou_greedy_track_association: done, errors");
            $finish;
        end
    end

    // receiver: check accepted words, stall on a changing pattern
    initial begin
        trk_ch.ready = 1'b0;
        rx_mode = 0;
        rx_hold = 0;
    end
    always @(posedge i_clk) begin
        if (i_rst_n && trk_ch.valid && trk_ch.ready)
            sb.check_word('{kind: trk_ch.kind, track_id: trk_ch.track_id,
                            out_x: trk_ch.out_x, out_y: trk_ch.out_y, out_w: trk_ch.out_w,
                            out_h: trk_ch.out_h, out_confidence: trk_ch.out_confidence,
                            age: trk_ch.age, last_update: trk_ch.last_update,
                            vel_x: trk_ch.vel_x, vel_y: trk_ch.vel_y, last: trk_ch.last});
        if (cycles % 300 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: trk_ch.ready <= 1'b1;
            1: trk_ch.ready <= $urandom_range(0, 1);
            2: trk_ch.ready <= (cycles % 4 == 0);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    trk_ch.ready <= 1'b0;
                end else begin
                    trk_ch.ready <= 1'b1;
                    if ($urandom_range(0, 9) == 0) rx_hold = $urandom_range(5, 40);
                end
            end
        endcase
    end

    function automatic det_word_t make_det(logic act, int x, int y, int w, int h,
                                           int c, int f);
        det_word_t d;
        d.action       = act;
        d.box_x        = x[COORD_W-1:0];
        d.box_y        = y[COORD_W-1:0];
        d.box_w        = w[SIZE_W-1:0];
        d.box_h        = h[SIZE_W-1:0];
        d.confidence   = c[CONF_W-1:0];
        d.frame_number = f[FRAME_W-1:0];
        return d;
    endfunction

    // drive one word in bursts with random gaps
    task automatic send_word(det_word_t d);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                det_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        det_ch.action       <= d.action;
        det_ch.box_x        <= d.box_x;
        det_ch.box_y        <= d.box_y;
        det_ch.box_w        <= d.box_w;
        det_ch.box_h        <= d.box_h;
        det_ch.confidence   <= d.confidence;
        det_ch.frame_number <= d.frame_number;
        det_ch.valid        <= 1'b1;
        @(posedge i_clk);
        while (!det_ch.ready) @(posedge i_clk);
        sb.note_word(d);
        words_sent++;
    endtask

    task automatic end_frame();
        send_word(make_det(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        frame_no++;
    endtask

    // let the block go idle, then write all three registers
    task automatic set_regs(int ct, int it, int ma);
        det_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= CFG_CONF_THR; i_cfg_data <= CFG_DATA_W'(ct);
        sb.write_reg(CFG_CONF_THR, CFG_DATA_W'(ct));
        @(posedge i_clk);
        i_cfg_idx <= CFG_IOU_THR; i_cfg_data <= CFG_DATA_W'(it);
        sb.write_reg(CFG_IOU_THR, CFG_DATA_W'(it));
        @(posedge i_clk);
        i_cfg_idx <= CFG_MAX_AGE; i_cfg_data <= CFG_DATA_W'(ma);
        sb.write_reg(CFG_MAX_AGE, CFG_DATA_W'(ma));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int clamp16(int v);
        return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    task automatic respawn(int i);
        obj_w[i] = $urandom_range(20, 300);
        obj_h[i] = $urandom_range(20, 300);
        if ($urandom_range(0, 7) == 0) obj_x[i] = 32767 - $urandom_range(0, 400);
        else obj_x[i] = $urandom_range(0, 60000) - 30000;
        obj_y[i] = $urandom_range(0, 60000) - 30000;
        obj_vx[i] = $urandom_range(0, 40) - 20;
        obj_vy[i] = $urandom_range(0, 40) - 20;
    endtask

    // one frame of moving objects with jitter, misses and newcomers
    task automatic scene_frame();
        int c;
        for (int i = 0; i < 5; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(sb.conf_thr, 65535);
                send_word(make_det(1'b0,
                    clamp16(obj_x[i] + $urandom_range(0, 6) - 3),
                    clamp16(obj_y[i] + $urandom_range(0, 6) - 3),
                    obj_w[i] + $urandom_range(0, 4) - 2,
                    obj_h[i] + $urandom_range(0, 4) - 2, c, frame_no));
            end
        end
        if ($urandom_range(0, 3) == 0)
            send_word(make_det(1'b0, $urandom_range(0, 60000) - 30000,
                               $urandom_range(0, 60000) - 30000, $urandom_range(1, 200),
                               $urandom_range(1, 200), $urandom_range(sb.conf_thr, 65535),
                               frame_no));
        end_frame();
        for (int i = 0; i < 5; i++) begin
            obj_x[i] += obj_vx[i];
            obj_y[i] += obj_vy[i];
            if (obj_x[i] > 32600 || obj_x[i] < -32700 || obj_y[i] > 32600 ||
                obj_y[i] < -32700 || $urandom_range(0, 19) == 0)
                respawn(i);
        end
    endtask

    // fully random words, every bit of every field
    task automatic noise_words();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) begin
            send_word(make_det(($urandom_range(0, 3) == 0), $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom));
        end
    endtask

    task automatic random_phase(int count);
        int stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) noise_words();
            else scene_frame();
        end
        end_frame();
    endtask

    // stimulus
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_CONF_THR;
        i_cfg_data   = '0;
        det_ch.valid = 1'b0;
        det_ch.action = 1'b0;
        det_ch.box_x = '0; det_ch.box_y = '0; det_ch.box_w = '0; det_ch.box_h = '0;
        det_ch.confidence = '0; det_ch.frame_number = '0;
        burst_left = 0;
        words_sent = 0;
        frame_no = 1;
        for (int i = 0; i < 5; i++) respawn(i);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, zero-area box, threshold edge
        send_word(make_det(1'b0, -32768, -32768, 0, 0, 65535, 0));
        send_word(make_det(1'b0, 0, 0, 10, 10, 32767, 5));
        send_word(make_det(1'b0, 32767, 32767, 8191, 8191, 32768, 32'h7fffffff));
        end_frame();
        // zero union never matches, exact match, repeated match
        send_word(make_det(1'b0, -32768, -32768, 0, 0, 40000, 1));
        send_word(make_det(1'b0, 32767, 32767, 8191, 8191, 50000, 2));
        send_word(make_det(1'b0, 32767, 32767, 8191, 8191, 50001, 3));
        end_frame();
        // moving box near the edge, then coasting into saturation
        send_word(make_det(1'b0, 32500, -32700, 200, 200, 60000, 10));
        end_frame();
        send_word(make_det(1'b0, 32560, -32760, 200, 200, 60000, 11));
        repeat (4) end_frame();
        // full table: two identical boxes first for the tie
        for (int i = 0; i < 18; i++)
            send_word(make_det(1'b0, (i < 2) ? 100 : i * 1000, 0, 50, 50, 65535, 20));
        end_frame();
        send_word(make_det(1'b0, 100, 0, 50, 50, 65535, 21));
        end_frame();
        end_frame();

        // random phases across register settings
        random_phase(40);
        set_regs(0, 0, 255);
        random_phase(40);
        set_regs(65535, 65535, 1);
        random_phase(25);
        set_regs($urandom_range(0, 40000), $urandom_range(0, 50000), 0);
        random_phase(30);
        set_regs($urandom_range(0, 40000), $urandom_range(10000, 40000),
                 $urandom_range(2, 12));
        random_phase(60);

        det_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_iou_greedy_track_association: done, clean");
        else
            $display("tb_iou_greedy_track_association: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
hdl/igta_pkg.sv
hdl/igta_if.sv
hdl/igta_mul.sv
hdl/igta_table.sv
hdl/iou_greedy_track_association.sv
dv/tb_iou_greedy_track_association.sv
